/* design/assert_macros.svh */
// Assertion macros used by the sorted request queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of i_clk while i_rst_n is high.
`define SRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define SRQ_ASSERT_NEXT(lbl, pre, post, msg) \
    `SRQ_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* design/srq_pkg.sv */
// Types, constants and the ordering helper function of the sorted request queue.
package srq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int FUNC_W = 2;
    localparam int PID_W = 8;
    localparam int PRIO_W = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W = 4;
    localparam int COUNT_W = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_MV_RD,
        S_MV_WR,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [PID_W-1:0]  pid;
    } t_entry;

    // True when the new pair must be served before the stored entry.
    function automatic logic goes_before(input logic [PRIO_W-1:0] prio,
                                         input logic [PID_W-1:0] pid,
                                         input t_entry ent);
        logic lt;
        lt = (prio < ent.prio) || ((prio == ent.prio) && (pid < ent.pid));
        return lt;
    endfunction

endpackage

/* design/srq_req_if.sv */
// Request channel of the sorted request queue.
interface srq_req_if;
    logic                         valid;
    logic                         ready;
    logic [srq_pkg::FUNC_W-1:0]   func;
    logic [srq_pkg::PID_W-1:0]    process_id;
    logic [srq_pkg::PRIO_W-1:0]   priority_req;

    modport source (output valid, func, process_id, priority_req, input ready);
    modport sink   (input valid, func, process_id, priority_req, output ready);
endinterface

/* design/srq_rsp_if.sv */
// Response channel of the sorted request queue.
interface srq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [srq_pkg::STATUS_W-1:0]  status;
    logic [srq_pkg::POS_W-1:0]     position;
    logic [srq_pkg::COUNT_W-1:0]   count;
    logic                          head_valid;
    logic [srq_pkg::PID_W-1:0]     head_process;
    logic [srq_pkg::PRIO_W-1:0]    head_priority;

    modport source (output valid, status, position, count, head_valid, head_process,
                    head_priority, input ready);
    modport sink   (input valid, status, position, count, head_valid, head_process,
                    head_priority, output ready);
endinterface

/* design/sorted_request_queue.sv */
// Sorted request queue: up to DEPTH (priority, process id) entries kept in order.
// The request channel i_req carries func, process_id and priority_req. Insert
// places a pair at its sorted slot, remove deletes the first entry with an id,
// and find reports the slot of the first entry with an id. Each request yields
// one transfer on o_rsp with status, position, entry count and head entry.
// Entries live in a single-port-write, single-port-read memory with a
// registered read. A small sequencer compares each entry in a scan state and a
// compare state, and moves each entry in a read state and a write state. The
// next request is accepted in the cycle after the response is registered. A
// full insert or a NOP goes from idle straight to the done state, which
// registers the response. i_req.ready is high only while the sequencer is idle.
// The response sits in an output register, so the next request is accepted
// while the previous response still waits; a stalled o_rsp only holds the
// sequencer once a second response is ready.
// Synchronous reset empties the queue and drops any pending response; the
// memory contents are not cleared, since only slots below the count are read.
`include "assert_macros.svh"

module sorted_request_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srq_req_if.sink           i_req,
    srq_rsp_if.source         o_rsp
);

    srq_pkg::t_state                 r_state, n_state;
    logic [srq_pkg::CNT_W-1:0]       r_count;
    srq_pkg::t_func                  r_func;
    logic [srq_pkg::PID_W-1:0]       r_id;
    logic [srq_pkg::PRIO_W-1:0]      r_prio;
    logic [srq_pkg::CNT_W-1:0]       r_idx;
    logic [srq_pkg::CNT_W-1:0]       r_j;
    logic [srq_pkg::CNT_W-1:0]       r_pos;
    srq_pkg::t_status                r_status;
    srq_pkg::t_entry                 r_head;
    srq_pkg::t_entry                 r_rd;
    srq_pkg::t_entry                 r_mem [srq_pkg::DEPTH];

    logic                            r_out_valid;
    logic [srq_pkg::STATUS_W-1:0]    r_out_status;
    logic [srq_pkg::POS_W-1:0]       r_out_pos;
    logic [srq_pkg::COUNT_W-1:0]     r_out_count;
    logic                            r_out_hv;
    logic [srq_pkg::PID_W-1:0]       r_out_hpid;
    logic [srq_pkg::PRIO_W-1:0]      r_out_hprio;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_scan_end;
    logic                            w_hit;
    logic                            w_ins;
    logic                            w_mv_more;
    logic                            w_in_ready;
    logic                            w_we;
    logic [srq_pkg::CNT_W-1:0]       w_rd_sel;
    logic [srq_pkg::CNT_W-1:0]       w_wr_sel;
    srq_pkg::t_entry                 w_wd;
    logic [srq_pkg::CNT_W-1:0]       w_res_count;
    srq_pkg::t_func                  w_in_func;
    logic                            w_wr_state;
    logic                            w_full_rsp;
    logic                            w_q_full;

    assign w_in_func  = srq_pkg::t_func'(i_req.func);
    assign w_accept   = i_req.valid && w_in_ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_ins      = (r_func == srq_pkg::FUNC_INSERT);
    assign w_scan_end = (r_idx == r_count);
    assign w_hit      = w_ins ? srq_pkg::goes_before(r_prio, r_id, r_rd)
                              : (r_rd.pid == r_id);
    assign w_mv_more  = w_ins ? ((r_j - 1'b1) != r_pos)
                              : (({1'b0, r_j} + (srq_pkg::CNT_W+1)'(2)) < {1'b0, r_count});
    assign w_wr_state = (r_state == srq_pkg::S_MV_WR) || (r_state == srq_pkg::S_PUT);
    assign w_full_rsp = r_out_valid && (r_out_status == srq_pkg::ST_FULL);
    assign w_q_full   = (r_count == srq_pkg::CNT_W'(srq_pkg::DEPTH));

    always_comb begin
        w_res_count = r_count;
        if (r_status == srq_pkg::ST_OK) begin
            if (r_func == srq_pkg::FUNC_INSERT) begin
                w_res_count = r_count + 1'b1;
            end else if (r_func == srq_pkg::FUNC_REMOVE) begin
                w_res_count = r_count - 1'b1;
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_func)
                        srq_pkg::FUNC_INSERT: begin
                            n_state = (r_count == srq_pkg::CNT_W'(srq_pkg::DEPTH))
                                      ? srq_pkg::S_DONE : srq_pkg::S_SCAN;
                        end
                        srq_pkg::FUNC_REMOVE,
                        srq_pkg::FUNC_FIND:   n_state = srq_pkg::S_SCAN;
                        srq_pkg::FUNC_NOP:    n_state = srq_pkg::S_DONE;
                        default:              n_state = srq_pkg::S_DONE;
                    endcase
                end
            end
            srq_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = w_ins ? srq_pkg::S_PUT : srq_pkg::S_DONE;
                end else begin
                    n_state = srq_pkg::S_CMP;
                end
            end
            srq_pkg::S_CMP: begin
                if (!w_hit) begin
                    n_state = srq_pkg::S_SCAN;
                end else if (w_ins) begin
                    n_state = srq_pkg::S_MV_RD;
                end else if (r_func == srq_pkg::FUNC_REMOVE &&
                             ({1'b0, r_idx} + 1'b1) < {1'b0, r_count}) begin
                    n_state = srq_pkg::S_MV_RD;
                end else begin
                    n_state = srq_pkg::S_DONE;
                end
            end
            srq_pkg::S_MV_RD: n_state = srq_pkg::S_MV_WR;
            srq_pkg::S_MV_WR: begin
                if (w_mv_more) begin
                    n_state = srq_pkg::S_MV_RD;
                end else begin
                    n_state = w_ins ? srq_pkg::S_PUT : srq_pkg::S_DONE;
                end
            end
            srq_pkg::S_PUT:   n_state = srq_pkg::S_DONE;
            srq_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = srq_pkg::S_IDLE;
                end
            end
            default: n_state = srq_pkg::S_IDLE;
        endcase
    end

    // Output logic: handshake and memory port controls.
    always_comb begin
        w_in_ready = 1'b0;
        w_we       = 1'b0;
        w_rd_sel   = r_idx;
        w_wr_sel   = r_j;
        w_wd       = r_rd;
        unique case (r_state)
            srq_pkg::S_IDLE:  w_in_ready = i_rst_n;
            srq_pkg::S_SCAN:  w_rd_sel = r_idx;
            srq_pkg::S_MV_RD: w_rd_sel = w_ins ? (r_j - 1'b1) : (r_j + 1'b1);
            srq_pkg::S_MV_WR: begin
                w_we     = 1'b1;
                w_wr_sel = r_j;
                w_wd     = r_rd;
            end
            srq_pkg::S_PUT: begin
                w_we      = 1'b1;
                w_wr_sel  = r_pos;
                w_wd.prio = r_prio;
                w_wd.pid  = r_id;
            end
            srq_pkg::S_CMP,
            srq_pkg::S_DONE: w_in_ready = 1'b0;
            default:         w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_sel[srq_pkg::IDX_W-1:0]];
        if (w_we) begin
            r_mem[w_wr_sel[srq_pkg::IDX_W-1:0]] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && w_wr_sel == '0) begin
            r_head <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == srq_pkg::S_DONE && w_out_free) begin
            r_count <= w_res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            srq_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_func   <= w_in_func;
                    r_id     <= i_req.process_id;
                    r_prio   <= i_req.priority_req;
                    r_idx    <= '0;
                    r_pos    <= '0;
                    r_status <= (w_in_func == srq_pkg::FUNC_INSERT &&
                                 r_count == srq_pkg::CNT_W'(srq_pkg::DEPTH))
                                ? srq_pkg::ST_FULL : srq_pkg::ST_OK;
                end
            end
            srq_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    if (w_ins) begin
                        r_pos <= r_idx;
                        r_j   <= r_idx;
                    end else begin
                        r_status <= srq_pkg::ST_NOTFOUND;
                    end
                end
            end
            srq_pkg::S_CMP: begin
                if (w_hit) begin
                    r_pos <= r_idx;
                    r_j   <= w_ins ? r_count : r_idx;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            srq_pkg::S_MV_WR: r_j <= w_ins ? (r_j - 1'b1) : (r_j + 1'b1);
            srq_pkg::S_MV_RD,
            srq_pkg::S_PUT,
            srq_pkg::S_DONE: r_j <= r_j;
            default:         r_j <= r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == srq_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == srq_pkg::S_DONE && w_out_free) begin
            r_out_status <= r_status;
            r_out_pos    <= srq_pkg::POS_W'(r_pos);
            r_out_count  <= srq_pkg::COUNT_W'(w_res_count);
            r_out_hv     <= (w_res_count != '0);
            r_out_hpid   <= (w_res_count != '0) ? r_head.pid : '0;
            r_out_hprio  <= (w_res_count != '0) ? r_head.prio : '0;
        end
    end

    assign i_req.ready         = w_in_ready;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.position      = r_out_pos;
    assign o_rsp.count         = r_out_count;
    assign o_rsp.head_valid    = r_out_hv;
    assign o_rsp.head_process  = r_out_hpid;
    assign o_rsp.head_priority = r_out_hprio;

    `SRQ_ASSERT(a_count_bound, r_count <= srq_pkg::CNT_W'(srq_pkg::DEPTH), "count above depth")
    `SRQ_ASSERT(a_write_state, w_we |-> w_wr_state, "memory write outside a move or put")
    `SRQ_ASSERT(a_full_count, w_full_rsp |-> w_q_full, "full status without a full queue")
    `SRQ_ASSERT_NEXT(a_leave_idle, w_accept, r_state != srq_pkg::S_IDLE, "accept left idle")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the sorted request queue with directed and random traffic.
module testbench;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int TABLE_ROWS = 27;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 4 * srq_pkg::DEPTH + 8;
    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        srq_pkg::t_status                   status;
        logic [srq_pkg::POS_W-1:0]          position;
        logic [srq_pkg::COUNT_W-1:0]        count;
        logic                               head_valid;
        logic [srq_pkg::PID_W-1:0]          head_process;
        logic [srq_pkg::PRIO_W-1:0]         head_priority;
    } t_queue_result;

    typedef struct packed {
        srq_pkg::t_func                     op;
        logic [srq_pkg::PID_W-1:0]          pid;
        logic [srq_pkg::PRIO_W-1:0]         prio;
        logic                               has_want;
        t_queue_result                      want;
    } t_table_row;

    localparam t_queue_result NO_WANT = '0;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic [srq_pkg::FUNC_W-1:0] req_func = '0;
    logic [srq_pkg::PID_W-1:0] req_pid = '0;
    logic [srq_pkg::PRIO_W-1:0] req_prio = '0;
    logic rsp_take = 1'b0;

    logic [srq_pkg::PRIO_W-1:0] queue_prio [srq_pkg::DEPTH];
    logic [srq_pkg::PID_W-1:0] queue_pid [srq_pkg::DEPTH];
    int queue_count = 0;
    t_queue_result pending_results [$];
    t_table_row directed_rows [TABLE_ROWS];
    int errors = 0;
    int idle_cycles = 0;
    int take_hold = 0;

    srq_req_if req_ch();
    srq_rsp_if rsp_ch();

    assign req_ch.valid = req_valid;
    assign req_ch.func = req_func;
    assign req_ch.process_id = req_pid;
    assign req_ch.priority_req = req_prio;
    assign rsp_ch.ready = rsp_take;

    sorted_request_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_queue_result predict_queue_op(srq_pkg::t_func op,
                                                       logic [srq_pkg::PID_W-1:0] pid,
                                                       logic [srq_pkg::PRIO_W-1:0] prio);
        t_queue_result res;
        int slot;
        int j;
        res = '0;
        res.status = srq_pkg::ST_OK;
        slot = 0;
        case (op)
            srq_pkg::FUNC_INSERT: begin
                if (queue_count >= srq_pkg::DEPTH) begin
                    res.status = srq_pkg::ST_FULL;
                end else begin
                    while (slot < queue_count && !(prio < queue_prio[slot] ||
                           (prio == queue_prio[slot] && pid < queue_pid[slot])))
                        slot++;
                    for (j = queue_count; j > slot; j--) begin
                        queue_prio[j] = queue_prio[j-1];
                        queue_pid[j] = queue_pid[j-1];
                    end
                    queue_prio[slot] = prio;
                    queue_pid[slot] = pid;
                    queue_count++;
                    res.position = srq_pkg::POS_W'(slot);
                end
            end
            srq_pkg::FUNC_REMOVE, srq_pkg::FUNC_FIND: begin
                while (slot < queue_count && queue_pid[slot] != pid)
                    slot++;
                if (slot == queue_count) begin
                    res.status = srq_pkg::ST_NOTFOUND;
                end else begin
                    res.position = srq_pkg::POS_W'(slot);
                    if (op == srq_pkg::FUNC_REMOVE) begin
                        for (j = slot; j < queue_count - 1; j++) begin
                            queue_prio[j] = queue_prio[j+1];
                            queue_pid[j] = queue_pid[j+1];
                        end
                        queue_count--;
                    end
                end
            end
            default: ;
        endcase
        res.count = srq_pkg::COUNT_W'(queue_count);
        if (queue_count > 0) begin
            res.head_valid = 1'b1;
            res.head_process = queue_pid[0];
            res.head_priority = queue_prio[0];
        end
        return res;
    endfunction

    function automatic int random_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task automatic send_request(srq_pkg::t_func op, logic [srq_pkg::PID_W-1:0] pid,
                                logic [srq_pkg::PRIO_W-1:0] prio,
                                logic has_want, t_queue_result want);
        t_queue_result predicted;
        req_valid = 1'b1;
        req_func = op;
        req_pid = pid;
        req_prio = prio;
        do
            @(posedge i_clk);
        while (req_ch.ready !== 1'b1);
        predicted = predict_queue_op(op, pid, prio);
        pending_results.push_back(has_want ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            req_valid = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        req_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : rsp_pacing
        int roll;
        if (take_hold > 0) begin
            take_hold = take_hold - 1;
        end else begin
            roll = $urandom_range(99);
            if (roll < 50) begin
                rsp_take <= 1'b1;
                take_hold = $urandom_range(30, 1) - 1;
            end else if (roll < 92) begin
                rsp_take <= 1'b0;
                take_hold = $urandom_range(3, 1) - 1;
            end else begin
                rsp_take <= 1'b0;
                take_hold = $urandom_range(60, 20) - 1;
            end
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_queue_result want;
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_take) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("response with none expected, count %0d",
                                          rsp_ch.count));
            end else begin
                want = pending_results.pop_front();
                compare_field("status", rsp_ch.status, want.status);
                compare_field("position", rsp_ch.position, want.position);
                compare_field("count", rsp_ch.count, want.count);
                compare_field("head_valid", rsp_ch.head_valid, want.head_valid);
                compare_field("head_process", rsp_ch.head_process, want.head_process);
                compare_field("head_priority", rsp_ch.head_priority, want.head_priority);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_valid && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_take))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int r;
        int n;
        int roll;
        int insert_pct;
        logic steady;
        srq_pkg::t_func op;
        logic [srq_pkg::PID_W-1:0] pid;
        logic [srq_pkg::PRIO_W-1:0] prio;

        directed_rows[0]  = '{srq_pkg::FUNC_FIND, 8'h05, 32'h0, 1'b1,
                              '{srq_pkg::ST_NOTFOUND, 4'd0, 5'd0, 1'b0, 8'h00, 32'h0}};
        directed_rows[1]  = '{srq_pkg::FUNC_REMOVE, 8'h05, 32'h0, 1'b1,
                              '{srq_pkg::ST_NOTFOUND, 4'd0, 5'd0, 1'b0, 8'h00, 32'h0}};
        directed_rows[2]  = '{srq_pkg::FUNC_NOP, 8'h00, 32'h0, 1'b1,
                              '{srq_pkg::ST_OK, 4'd0, 5'd0, 1'b0, 8'h00, 32'h0}};
        directed_rows[3]  = '{srq_pkg::FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
                              '{srq_pkg::ST_OK, 4'd0, 5'd1, 1'b1, 8'hFF, 32'hFFFF_FFFF}};
        directed_rows[4]  = '{srq_pkg::FUNC_INSERT, 8'h00, 32'h0, 1'b1,
                              '{srq_pkg::ST_OK, 4'd0, 5'd2, 1'b1, 8'h00, 32'h0}};
        directed_rows[5]  = '{srq_pkg::FUNC_INSERT, 8'h01, 32'h0, 1'b0, NO_WANT};
        directed_rows[6]  = '{srq_pkg::FUNC_INSERT, 8'h00, 32'h0, 1'b0, NO_WANT};
        directed_rows[7]  = '{srq_pkg::FUNC_INSERT, 8'hFF, 32'h5, 1'b0, NO_WANT};
        directed_rows[8]  = '{srq_pkg::FUNC_FIND, 8'hFF, 32'h0, 1'b0, NO_WANT};
        directed_rows[9]  = '{srq_pkg::FUNC_REMOVE, 8'hFF, 32'h0, 1'b0, NO_WANT};
        directed_rows[10] = '{srq_pkg::FUNC_NOP, 8'hAA, 32'h1234, 1'b0, NO_WANT};
        directed_rows[11] = '{srq_pkg::FUNC_INSERT, 8'h80, 32'h8000_0000, 1'b0, NO_WANT};
        directed_rows[12] = '{srq_pkg::FUNC_INSERT, 8'h7F, 32'h7FFF_FFFF, 1'b0, NO_WANT};
        directed_rows[13] = '{srq_pkg::FUNC_INSERT, 8'h55, 32'h5555_5555, 1'b0, NO_WANT};
        directed_rows[14] = '{srq_pkg::FUNC_INSERT, 8'hAA, 32'hAAAA_AAAA, 1'b0, NO_WANT};
        directed_rows[15] = '{srq_pkg::FUNC_INSERT, 8'h01, 32'h1, 1'b0, NO_WANT};
        directed_rows[16] = '{srq_pkg::FUNC_INSERT, 8'hFE, 32'hFFFF_FFFE, 1'b0, NO_WANT};
        directed_rows[17] = '{srq_pkg::FUNC_INSERT, 8'h00, 32'hFFFF_FFFF, 1'b0, NO_WANT};
        directed_rows[18] = '{srq_pkg::FUNC_INSERT, 8'h10, 32'h10, 1'b0, NO_WANT};
        directed_rows[19] = '{srq_pkg::FUNC_INSERT, 8'h20, 32'h20, 1'b0, NO_WANT};
        directed_rows[20] = '{srq_pkg::FUNC_INSERT, 8'h30, 32'h30, 1'b0, NO_WANT};
        directed_rows[21] = '{srq_pkg::FUNC_INSERT, 8'h40, 32'h40, 1'b0, NO_WANT};
        directed_rows[22] = '{srq_pkg::FUNC_INSERT, 8'h50, 32'h50, 1'b0, NO_WANT};
        directed_rows[23] = '{srq_pkg::FUNC_INSERT, 8'h33, 32'h3, 1'b1,
                              '{srq_pkg::ST_FULL, 4'd0, 5'd16, 1'b1, 8'h00, 32'h0}};
        directed_rows[24] = '{srq_pkg::FUNC_REMOVE, 8'h99, 32'h0, 1'b1,
                              '{srq_pkg::ST_NOTFOUND, 4'd0, 5'd16, 1'b1, 8'h00, 32'h0}};
        directed_rows[25] = '{srq_pkg::FUNC_FIND, 8'hFF, 32'h0, 1'b0, NO_WANT};
        directed_rows[26] = '{srq_pkg::FUNC_REMOVE, 8'h00, 32'h0, 1'b0, NO_WANT};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < TABLE_ROWS; r++) begin
            send_request(directed_rows[r].op, directed_rows[r].pid, directed_rows[r].prio,
                         directed_rows[r].has_want, directed_rows[r].want);
            pause_sender(random_gap());
        end
        wait_for_drain();

        insert_pct = 50;
        steady = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                steady = ($urandom_range(3) == 0);
            end
            if (n % 150 == 75)
                wait_for_drain();

            roll = $urandom_range(99);
            if (roll < 4)
                op = srq_pkg::FUNC_NOP;
            else if (roll < 4 + insert_pct)
                op = srq_pkg::FUNC_INSERT;
            else if (roll[0])
                op = srq_pkg::FUNC_REMOVE;
            else
                op = srq_pkg::FUNC_FIND;

            if (op != srq_pkg::FUNC_INSERT && queue_count > 0 && $urandom_range(9) < 8)
                pid = queue_pid[$urandom_range(queue_count - 1)];
            else if ($urandom_range(1))
                pid = srq_pkg::PID_W'($urandom_range(7));
            else
                pid = srq_pkg::PID_W'($urandom_range(255));

            roll = $urandom_range(19);
            if (roll < 3)
                prio = ($urandom_range(2) == 0) ? 32'h0 :
                       ($urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
            else if (roll < 10)
                prio = srq_pkg::PRIO_W'($urandom_range(3));
            else
                prio = $urandom();

            send_request(op, pid, prio, 1'b0, NO_WANT);
            if (!steady)
                pause_sender(random_gap());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
